@@ rtl/asrd_pkg.sv @@
// ----------------------------------------------------------------------------
// Audio sample rate detector package
// Shared widths, register indexes, reset values and the command and status
// structures that join the controller and the datapath.
// ----------------------------------------------------------------------------
package asrd_pkg;

   localparam int STAMP_W   = 32;
   localparam int FRAMES_W  = 14;
   localparam int RATE_W    = 18;
   localparam int MEAS_W    = 20;
   localparam int TOL_W     = 16;
   localparam int NUMER_W   = 34;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 18;
   localparam int CNT_W     = 2;
   localparam int TABLE_SLOTS = 4;
   localparam int DIV_CNT_W = 6;

   localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 6'd34;
   localparam logic [MEAS_W-1:0]    RATE_SAT  = 20'hFFFFF;
   localparam logic [MEAS_W-1:0]    US_PER_S  = 20'd1000000;

   localparam logic [CSR_IDX_W-1:0] REG_PERIOD_FRAMES = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INITIAL_RATE  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TABLE_RATE_0  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_TABLE_RATE_1  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_TABLE_RATE_2  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_TABLE_RATE_3  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_TOLERANCE_HZ  = 3'd6;

   localparam logic [FRAMES_W-1:0] RST_PERIOD_FRAMES = 14'd1024;
   localparam logic [RATE_W-1:0]   RST_INITIAL_RATE  = 18'd48000;
   localparam logic [RATE_W-1:0]   RST_TABLE_RATE_0  = 18'd44100;
   localparam logic [RATE_W-1:0]   RST_TABLE_RATE_1  = 18'd48000;
   localparam logic [RATE_W-1:0]   RST_TABLE_RATE_2  = 18'd88200;
   localparam logic [RATE_W-1:0]   RST_TABLE_RATE_3  = 18'd96000;
   localparam logic [TOL_W-1:0]    RST_TOLERANCE_HZ  = 16'd1000;

   localparam logic EVENT_CHANGE = 1'b0;
   localparam logic EVENT_RETRY  = 1'b1;

   typedef struct packed {
      logic accept;
      logic div_start;
      logic load_rate;
      logic count_step;
      logic set_retry;
      logic search_init;
      logic search_step;
      logic set_change;
      logic rsp_load;
   } asrd_cmd_type;

   typedef struct packed {
      logic stamp_seen;
      logic div_done;
      logic within_tol;
      logic confirm;
      logic out_of_span;
      logic search_last;
      logic snap_same;
      logic rsp_free;
   } asrd_sts_type;

endpackage

@@ rtl/asrd_div.sv @@
// ----------------------------------------------------------------------------
// Serial divider
// Restoring unsigned division of a 34-bit dividend by a 32-bit divisor, one
// quotient bit per cycle, with a one-cycle done pulse.
// ----------------------------------------------------------------------------
module asrd_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [asrd_pkg::NUMER_W-1:0]   numer,
   input  logic [asrd_pkg::STAMP_W-1:0]   denom,
   output logic                           done,
   output logic [asrd_pkg::NUMER_W-1:0]   quotient
);
   import asrd_pkg::*;

   logic [NUMER_W-1:0]   quo_ff, quo_in;
   logic [STAMP_W-1:0]   rem_ff, rem_in;
   logic [STAMP_W-1:0]   den_ff, den_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [STAMP_W:0]     trial;
   logic [STAMP_W+1:0]   diff;
   logic                 ge;

   always_comb begin
      trial = {rem_ff, quo_ff[NUMER_W-1]};
      diff  = {1'b0, trial} - {2'b00, den_ff};
      ge    = ~diff[STAMP_W+1];
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = numer;
         rem_in  = '0;
         den_in  = denom;
         cnt_in  = DIV_STEPS;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[NUMER_W-2:0], ge};
         rem_in = ge ? diff[STAMP_W-1:0] : trial[STAMP_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

`ifndef SYNTHESIS
   a_start_when_free: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");
   a_done_single: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("divider done held for more than one cycle");
`endif

endmodule

@@ rtl/asrd_dpath.sv @@
// ----------------------------------------------------------------------------
// Rate detector datapath
// Configuration registers, stamp and rate state, rate measurement through the
// serial divider, tolerance and span checks, table search and result word.
// ----------------------------------------------------------------------------
module asrd_dpath #(
   parameter int TABLE_ENTRIES = 4,
   parameter int CONFIRM_COUNT = 2
) (
   input  logic                             clock,
   input  logic                             reset,
   input  asrd_pkg::asrd_cmd_type           cmd,
   output asrd_pkg::asrd_sts_type           sts,
   input  logic                             csr_write_en,
   input  logic [asrd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [asrd_pkg::CSR_DAT_W-1:0]   csr_data,
   input  logic [asrd_pkg::STAMP_W-1:0]     req_stamp_us,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_event_kind,
   output logic [asrd_pkg::RATE_W-1:0]      rsp_new_rate,
   output logic [asrd_pkg::MEAS_W-1:0]      rsp_measured_rate
);
   import asrd_pkg::*;

   localparam int IDX_W     = $clog2(TABLE_ENTRIES);
   localparam int LAST_SLOT = (TABLE_ENTRIES > TABLE_SLOTS) ? TABLE_SLOTS - 1
                                                            : TABLE_ENTRIES - 1;

   logic [FRAMES_W-1:0] pf_ff, pf_in;
   logic [RATE_W-1:0]   init_ff, init_in;
   logic [RATE_W-1:0]   tbl_ff [TABLE_SLOTS];
   logic [RATE_W-1:0]   tbl_in [TABLE_SLOTS];
   logic [TOL_W-1:0]    tol_ff, tol_in;
   logic [STAMP_W-1:0]  last_ff, last_in;
   logic                seen_ff, seen_in;
   logic [RATE_W-1:0]   cur_ff, cur_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [STAMP_W-1:0]  interval_ff, interval_in;
   logic [MEAS_W-1:0]   rate_ff, rate_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [MEAS_W-1:0]   best_ff, best_in;
   logic [RATE_W-1:0]   pick_ff, pick_in;
   logic                res_kind_ff, res_kind_in;
   logic [RATE_W-1:0]   res_rate_ff, res_rate_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_kind_ff, rsp_kind_in;
   logic [RATE_W-1:0]   rsp_new_ff, rsp_new_in;
   logic [MEAS_W-1:0]   rsp_meas_ff, rsp_meas_in;

   logic [NUMER_W-1:0]  numer;
   logic [NUMER_W-1:0]  quotient;
   logic                div_done;
   logic [MEAS_W-1:0]   cur_dist;
   logic [CNT_W-1:0]    cnt_inc;
   logic                confirm;
   logic [MEAS_W:0]     rate_plus_tol;
   logic [MEAS_W:0]     span_high;
   logic [2:0]          idx_wide;
   logic [RATE_W-1:0]   entry_sel;
   logic [MEAS_W-1:0]   entry_dist;

   assign numer = NUMER_W'(pf_ff) * NUMER_W'(US_PER_S);

   asrd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .numer    (numer),
      .denom    (interval_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   always_comb begin
      cur_dist = ({2'b00, cur_ff} > rate_ff) ? ({2'b00, cur_ff} - rate_ff)
                                             : (rate_ff - {2'b00, cur_ff});
      cnt_inc  = (cnt_ff == '1) ? cnt_ff : cnt_ff + 1'b1;
      confirm  = cnt_inc >= CNT_W'(CONFIRM_COUNT);
      rate_plus_tol = {1'b0, rate_ff} + (MEAS_W + 1)'(tol_ff);
      span_high     = (MEAS_W + 1)'(tbl_ff[LAST_SLOT]) + (MEAS_W + 1)'(tol_ff);
      idx_wide  = 3'(idx_ff);
      entry_sel = (idx_wide > 3'(TABLE_SLOTS - 1)) ? tbl_ff[TABLE_SLOTS-1]
                                                   : tbl_ff[idx_wide[1:0]];
      entry_dist = ({2'b00, entry_sel} > rate_ff) ? ({2'b00, entry_sel} - rate_ff)
                                                  : (rate_ff - {2'b00, entry_sel});
   end

   always_comb begin
      pf_in       = pf_ff;
      init_in     = init_ff;
      tbl_in      = tbl_ff;
      tol_in      = tol_ff;
      last_in     = last_ff;
      seen_in     = seen_ff;
      cur_in      = cur_ff;
      cnt_in      = cnt_ff;
      interval_in = interval_ff;
      rate_in     = rate_ff;
      idx_in      = idx_ff;
      best_in     = best_ff;
      pick_in     = pick_ff;
      res_kind_in = res_kind_ff;
      res_rate_in = res_rate_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_new_in   = rsp_new_ff;
      rsp_meas_in  = rsp_meas_ff;

      if (csr_write_en) begin
         case (csr_index)
            REG_PERIOD_FRAMES: begin
               pf_in = csr_data[FRAMES_W-1:0];
            end
            REG_INITIAL_RATE: begin
               init_in = csr_data;
               cur_in  = csr_data;
            end
            REG_TABLE_RATE_0: begin
               tbl_in[0] = csr_data;
            end
            REG_TABLE_RATE_1: begin
               tbl_in[1] = csr_data;
            end
            REG_TABLE_RATE_2: begin
               tbl_in[2] = csr_data;
            end
            REG_TABLE_RATE_3: begin
               tbl_in[3] = csr_data;
            end
            REG_TOLERANCE_HZ: begin
               tol_in = csr_data[TOL_W-1:0];
            end
            default: begin
            end
         endcase
      end

      if (cmd.accept) begin
         seen_in     = 1'b1;
         last_in     = req_stamp_us;
         interval_in = req_stamp_us - last_ff;
      end

      if (cmd.load_rate) begin
         rate_in = ((interval_ff == '0) || (quotient[NUMER_W-1:MEAS_W] != '0))
                   ? RATE_SAT : quotient[MEAS_W-1:0];
      end

      if (cmd.count_step) begin
         cnt_in = confirm ? '0 : cnt_inc;
      end

      if (cmd.set_retry) begin
         res_kind_in = EVENT_RETRY;
         res_rate_in = cur_ff;
      end

      if (cmd.search_init) begin
         idx_in  = '0;
         best_in = '1;
      end

      if (cmd.search_step) begin
         idx_in = idx_ff + 1'b1;
         if (entry_dist <= best_ff) begin
            best_in = entry_dist;
            pick_in = entry_sel;
         end
      end

      if (cmd.set_change) begin
         res_kind_in = EVENT_CHANGE;
         res_rate_in = pick_ff;
         cur_in      = pick_ff;
      end

      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = res_kind_ff;
         rsp_new_in   = res_rate_ff;
         rsp_meas_in  = rate_ff;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pf_ff        <= RST_PERIOD_FRAMES;
         init_ff      <= RST_INITIAL_RATE;
         tbl_ff[0]    <= RST_TABLE_RATE_0;
         tbl_ff[1]    <= RST_TABLE_RATE_1;
         tbl_ff[2]    <= RST_TABLE_RATE_2;
         tbl_ff[3]    <= RST_TABLE_RATE_3;
         tol_ff       <= RST_TOLERANCE_HZ;
         last_ff      <= '0;
         seen_ff      <= 1'b0;
         cur_ff       <= RST_INITIAL_RATE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pf_ff        <= pf_in;
         init_ff      <= init_in;
         tbl_ff       <= tbl_in;
         tol_ff       <= tol_in;
         last_ff      <= last_in;
         seen_ff      <= seen_in;
         cur_ff       <= cur_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      interval_ff <= interval_in;
      rate_ff     <= rate_in;
      idx_ff      <= idx_in;
      best_ff     <= best_in;
      pick_ff     <= pick_in;
      res_kind_ff <= res_kind_in;
      res_rate_ff <= res_rate_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_new_ff  <= rsp_new_in;
      rsp_meas_ff <= rsp_meas_in;
   end

   always_comb begin
      sts.stamp_seen  = seen_ff;
      sts.div_done    = div_done;
      sts.within_tol  = cur_dist < MEAS_W'(tol_ff);
      sts.confirm     = confirm;
      sts.out_of_span = (rate_plus_tol < (MEAS_W + 1)'(tbl_ff[0]))
                        || ({1'b0, rate_ff} > span_high);
      sts.search_last = idx_ff == IDX_W'(TABLE_ENTRIES - 1);
      sts.snap_same   = pick_ff == cur_ff;
      sts.rsp_free    = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_event_kind    = rsp_kind_ff;
   assign rsp_new_rate      = rsp_new_ff;
   assign rsp_measured_rate = rsp_meas_ff;

`ifndef SYNTHESIS
   a_count_below_confirm: assert property (@(posedge clock) disable iff (reset)
      cnt_ff < CNT_W'(CONFIRM_COUNT))
      else $error("mismatch count reached the confirm level without clearing");
   a_no_word_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result word loaded over a word not yet taken");
`endif

endmodule

@@ rtl/asrd_ctrl.sv @@
// ----------------------------------------------------------------------------
// Rate detector controller
// State machine that sequences one stamp through measurement, checking,
// table search and delivery of the result word.
// ----------------------------------------------------------------------------
module asrd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  asrd_pkg::asrd_sts_type sts,
   output asrd_pkg::asrd_cmd_type cmd
);
   import asrd_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_MUL    = 3'd1;
   localparam logic [2:0] ST_DIV    = 3'd2;
   localparam logic [2:0] ST_RATE   = 3'd3;
   localparam logic [2:0] ST_CHECK  = 3'd4;
   localparam logic [2:0] ST_SEARCH = 3'd5;
   localparam logic [2:0] ST_DECIDE = 3'd6;
   localparam logic [2:0] ST_OUT    = 3'd7;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
            if (req_valid && sts.stamp_seen) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            if (sts.div_done) begin
               state_in = ST_RATE;
            end
         end
         ST_RATE: begin
            cmd.load_rate = 1'b1;
            state_in      = ST_CHECK;
         end
         ST_CHECK: begin
            if (sts.within_tol) begin
               state_in = ST_IDLE;
            end else begin
               cmd.count_step = 1'b1;
               if (!sts.confirm) begin
                  state_in = ST_IDLE;
               end else if (sts.out_of_span) begin
                  cmd.set_retry = 1'b1;
                  state_in      = ST_OUT;
               end else begin
                  cmd.search_init = 1'b1;
                  state_in        = ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            cmd.search_step = 1'b1;
            if (sts.search_last) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (sts.snap_same) begin
               state_in = ST_IDLE;
            end else begin
               cmd.set_change = 1'b1;
               state_in       = ST_OUT;
            end
         end
         ST_OUT: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/audio_sample_rate_detector.sv @@
// ----------------------------------------------------------------------------
// Audio sample rate detector
// Measures the audio rate from period timestamps, confirms a mismatch over
// several periods and reports a snapped rate change or an out-of-range retry.
//
//   Channel  Direction  Handshake             Word
//   req_     in         req_valid/req_stall   stamp_us
//   rsp_     out        rsp_valid/rsp_stall   event_kind, new_rate, measured_rate
//   csr_     in         csr_write_en          csr_index, csr_data
//
// The first stamp after reset is accepted and only recorded.
// Every later stamp is measured by the 34-step serial divider and checked, and
// may lead to a retry word or a table search; req_stall stays high until the
// controller is back in idle, and one word is in flight.
// A finished result waits in the output register, and the next stamp is
// accepted while it waits; a second result is held until the first is taken.
// Reset is synchronous and restores the configuration and control registers.
// ----------------------------------------------------------------------------
module audio_sample_rate_detector #(
   parameter int TABLE_ENTRIES = 4,
   parameter int CONFIRM_COUNT = 2
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [asrd_pkg::STAMP_W-1:0]     req_stamp_us,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_event_kind,
   output logic [asrd_pkg::RATE_W-1:0]      rsp_new_rate,
   output logic [asrd_pkg::MEAS_W-1:0]      rsp_measured_rate,
   input  logic                             csr_write_en,
   input  logic [asrd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [asrd_pkg::CSR_DAT_W-1:0]   csr_data
);
   import asrd_pkg::*;

   asrd_cmd_type cmd;
   asrd_sts_type sts;

   asrd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   asrd_dpath #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .CONFIRM_COUNT (CONFIRM_COUNT)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_stamp_us      (req_stamp_us),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_new_rate      (rsp_new_rate),
      .rsp_measured_rate (rsp_measured_rate)
   );

endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// Testbench for the audio sample rate detector
// Sends period timestamps through the valid/stall request channel. A
// predictor in the bench follows each accepted word and expects change and
// retry words in order. The run opens with directed checks of saturation,
// confirmation, snapping, ties and register writes. Random bursts at chosen
// rates follow under several register settings and idle patterns.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import asrd_pkg::*;

   localparam int TABLE_ENTRIES = 4;
   localparam int CONFIRM_COUNT = 2;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 3'd7;
   localparam int SETTLE_CYCLES = 120;
   localparam int DRAIN_LIMIT   = 20000;
   localparam int RANDOM_WORDS  = 533;
   localparam int PRINT_LIMIT   = 100;

   typedef struct packed {
      logic              event_kind;
      logic [RATE_W-1:0] new_rate;
      logic [MEAS_W-1:0] measured_rate;
   } rate_event_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [STAMP_W-1:0]   req_stamp_us;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic                 rsp_event_kind;
   logic [RATE_W-1:0]    rsp_new_rate;
   logic [MEAS_W-1:0]    rsp_measured_rate;
   logic                 csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_data;

   logic [FRAMES_W-1:0]  cfg_frames;
   logic [RATE_W-1:0]    cfg_initial;
   logic [RATE_W-1:0]    cfg_table [TABLE_SLOTS];
   logic [TOL_W-1:0]     cfg_tol;
   logic [STAMP_W-1:0]   st_last_stamp;
   logic                 st_seen;
   logic [RATE_W-1:0]    st_rate;
   logic [CNT_W-1:0]     st_misses;

   rate_event_type       pending_events [$];
   logic [STAMP_W-1:0]   stamp_cursor;
   int unsigned          words_sent;
   int unsigned          error_count;
   int unsigned          send_idle_pct;
   int unsigned          stall_pct;

   audio_sample_rate_detector u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_stamp_us      (req_stamp_us),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_new_rate      (rsp_new_rate),
      .rsp_measured_rate (rsp_measured_rate),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("FAIL audio_sample_rate_detector");
      $finish;
   end

   task automatic report_mismatch(input string what);
      if (error_count < PRINT_LIMIT) begin
         $display("ERROR at %0t ns: %s", $time, what);
      end
      error_count++;
   endtask

   function automatic longint table_entry(input int idx);
      return longint'(cfg_table[(idx < TABLE_SLOTS) ? idx : TABLE_SLOTS - 1]);
   endfunction

   function automatic bit predict_rate_event(input logic [STAMP_W-1:0] stamp,
                                             output rate_event_type ev);
      logic [STAMP_W-1:0] gap;
      longint unsigned    quot;
      longint             rate;
      longint             tol;
      longint             delta;
      longint             best;
      int                 pick;
      int                 i;
      ev = '0;
      if (!st_seen) begin
         st_seen = 1'b1;
         st_last_stamp = stamp;
         return 1'b0;
      end
      gap = stamp - st_last_stamp;
      st_last_stamp = stamp;
      if (gap == 0) begin
         quot = RATE_SAT;
      end else begin
         quot = (64'(cfg_frames) * 64'(US_PER_S)) / 64'(gap);
         if (quot > RATE_SAT) begin
            quot = RATE_SAT;
         end
      end
      rate  = longint'(quot);
      tol   = longint'(cfg_tol);
      delta = longint'(st_rate) - rate;
      if (delta < 0) begin
         delta = -delta;
      end
      if (delta < tol) begin
         return 1'b0;
      end
      if (st_misses < 3) begin
         st_misses++;
      end
      if (st_misses < CONFIRM_COUNT) begin
         return 1'b0;
      end
      st_misses = '0;
      ev.measured_rate = quot[MEAS_W-1:0];
      if (rate < table_entry(0) - tol || rate > table_entry(TABLE_ENTRIES - 1) + tol) begin
         ev.event_kind = EVENT_RETRY;
         ev.new_rate   = st_rate;
         return 1'b1;
      end
      pick = 0;
      best = table_entry(0) - rate;
      if (best < 0) begin
         best = -best;
      end
      for (i = 0; i < TABLE_ENTRIES; i++) begin
         delta = table_entry(i) - rate;
         if (delta < 0) begin
            delta = -delta;
         end
         if (delta <= best) begin
            best = delta;
            pick = i;
         end
      end
      if (table_entry(pick) == longint'(st_rate)) begin
         return 1'b0;
      end
      st_rate       = RATE_W'(table_entry(pick));
      ev.event_kind = EVENT_CHANGE;
      ev.new_rate   = st_rate;
      return 1'b1;
   endfunction

   function automatic void apply_reg(input logic [CSR_IDX_W-1:0] idx,
                                     input logic [CSR_DAT_W-1:0] data);
      case (idx)
         REG_PERIOD_FRAMES: cfg_frames = data[FRAMES_W-1:0];
         REG_INITIAL_RATE: begin
            cfg_initial = data[RATE_W-1:0];
            st_rate     = data[RATE_W-1:0];
         end
         REG_TABLE_RATE_0: cfg_table[0] = data[RATE_W-1:0];
         REG_TABLE_RATE_1: cfg_table[1] = data[RATE_W-1:0];
         REG_TABLE_RATE_2: cfg_table[2] = data[RATE_W-1:0];
         REG_TABLE_RATE_3: cfg_table[3] = data[RATE_W-1:0];
         REG_TOLERANCE_HZ: cfg_tol = data[TOL_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic logic [STAMP_W-1:0] gap_for_rate(input longint rate);
      longint numer;
      numer = longint'(cfg_frames) * longint'(US_PER_S);
      if (rate <= 0 || numer / rate > longint'(32'hFFFF_FFFF)) begin
         return $urandom;
      end
      return STAMP_W'(numer / rate);
   endfunction

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin : check_rsp
      rate_event_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_events.size() == 0) begin
            report_mismatch($sformatf("unexpected word kind %0d rate %0d measured %0d",
                                      rsp_event_kind, rsp_new_rate, rsp_measured_rate));
         end else begin
            want = pending_events.pop_front();
            if (rsp_event_kind !== want.event_kind) begin
               report_mismatch($sformatf("event_kind %0d, expected %0d",
                                         rsp_event_kind, want.event_kind));
            end
            if (rsp_new_rate !== want.new_rate) begin
               report_mismatch($sformatf("new_rate %0d, expected %0d",
                                         rsp_new_rate, want.new_rate));
            end
            if (rsp_measured_rate !== want.measured_rate) begin
               report_mismatch($sformatf("measured_rate %0d, expected %0d",
                                         rsp_measured_rate, want.measured_rate));
            end
         end
      end
   end

   task automatic send_stamp(input logic [STAMP_W-1:0] stamp);
      rate_event_type ev;
      req_valid    <= 1'b1;
      req_stamp_us <= stamp;
      do @(posedge clock); while (req_stall);
      if (predict_rate_event(stamp, ev)) begin
         pending_events.push_back(ev);
      end
      stamp_cursor = stamp;
      words_sent++;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic send_gap(input logic [STAMP_W-1:0] gap);
      send_stamp(stamp_cursor + gap);
   endtask

   task automatic wait_quiet();
      int waited = 0;
      req_valid <= 1'b0;
      while (pending_events.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_events.size() != 0) begin
         report_mismatch($sformatf("%0d expected words never arrived", pending_events.size()));
         pending_events.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_data     <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      apply_reg(idx, data);
      @(posedge clock);
   endtask

   task automatic randomize_config();
      logic [CSR_DAT_W-1:0] rates [TABLE_SLOTS];
      logic [CSR_DAT_W-1:0] swap;
      logic [CSR_DAT_W-1:0] frames;
      logic [CSR_DAT_W-1:0] tol;
      logic [CSR_DAT_W-1:0] init;
      int unsigned          style;
      int                   i;
      int                   j;
      style = $urandom_range(5);
      for (i = 0; i < TABLE_SLOTS; i++) begin
         rates[i] = CSR_DAT_W'($urandom);
      end
      frames = CSR_DAT_W'($urandom_range(1, 8192));
      tol    = CSR_DAT_W'($urandom_range(0, 3000));
      case (style)
         0: begin
            rates[0] = CSR_DAT_W'(RST_TABLE_RATE_0);
            rates[1] = CSR_DAT_W'(RST_TABLE_RATE_1);
            rates[2] = CSR_DAT_W'(RST_TABLE_RATE_2);
            rates[3] = CSR_DAT_W'(RST_TABLE_RATE_3);
            frames   = CSR_DAT_W'(RST_PERIOD_FRAMES);
            tol      = CSR_DAT_W'(RST_TOLERANCE_HZ);
         end
         2: begin
            rates[0] = 18'd0;
            rates[1] = 18'd1;
            rates[2] = 18'd2;
            rates[3] = 18'd3;
            frames   = 18'd1;
            tol      = 18'd0;
         end
         3: begin
            rates[0] = 18'd0;
            rates[1] = 18'd131072;
            rates[2] = 18'd262142;
            rates[3] = 18'd262143;
            frames   = 18'h3FFFF;
            tol      = 18'h3FFFF;
         end
         4: begin
            frames = CSR_DAT_W'($urandom);
            tol    = CSR_DAT_W'($urandom);
         end
         5: tol = CSR_DAT_W'($urandom_range(3000, 65535));
         default: ;
      endcase
      if (style == 1 || style == 5) begin
         for (i = 0; i < TABLE_SLOTS - 1; i++) begin
            for (j = 0; j < TABLE_SLOTS - 1 - i; j++) begin
               if (rates[j] > rates[j+1]) begin
                  swap       = rates[j];
                  rates[j]   = rates[j+1];
                  rates[j+1] = swap;
               end
            end
         end
      end
      init = $urandom_range(1) ? rates[$urandom_range(TABLE_SLOTS - 1)] : CSR_DAT_W'($urandom);
      write_reg(REG_PERIOD_FRAMES, frames);
      if ($urandom_range(3) != 0) begin
         write_reg(REG_INITIAL_RATE, init);
      end
      write_reg(REG_TABLE_RATE_0, rates[0]);
      write_reg(REG_TABLE_RATE_1, rates[1]);
      write_reg(REG_TABLE_RATE_2, rates[2]);
      write_reg(REG_TABLE_RATE_3, rates[3]);
      write_reg(REG_TOLERANCE_HZ, tol);
   endtask

   task automatic test_first_stamp_and_hold();
      send_stamp(32'hFFFF_C000);
      send_gap(21333);
      send_gap(21333);
   endtask

   task automatic test_saturation();
      send_gap(0);
      send_gap(1);
      send_gap(32'hFFFF_FFFF);
      send_gap(21333);
   endtask

   task automatic test_confirmed_change();
      send_gap(23220);
      send_gap(23220);
      send_gap(11610);
      send_gap(11610);
   endtask

   task automatic test_retry_out_of_span();
      send_gap(34133);
      send_gap(34133);
      send_gap(10240);
      send_gap(10240);
   endtask

   task automatic test_snap_keeps_rate();
      send_gap(11378);
      send_gap(11378);
   endtask

   task automatic test_tie_and_order();
      wait_quiet();
      write_reg(REG_PERIOD_FRAMES, 1);
      write_reg(REG_TOLERANCE_HZ, 0);
      write_reg(REG_TABLE_RATE_0, 40000);
      write_reg(REG_TABLE_RATE_1, 60000);
      write_reg(REG_TABLE_RATE_2, 250000);
      write_reg(REG_TABLE_RATE_3, 100000);
      write_reg(REG_INITIAL_RATE, 250000);
      send_gap(20);
      send_gap(20);
      send_gap(11);
      send_gap(11);
      send_gap(10);
      send_gap(10);
   endtask

   task automatic test_register_writes();
      wait_quiet();
      write_reg(REG_PERIOD_FRAMES, 18'h3C400);
      write_reg(REG_TOLERANCE_HZ, 18'h303E8);
      write_reg(REG_TABLE_RATE_0, RST_TABLE_RATE_0);
      write_reg(REG_TABLE_RATE_1, RST_TABLE_RATE_1);
      write_reg(REG_TABLE_RATE_2, RST_TABLE_RATE_2);
      write_reg(REG_TABLE_RATE_3, RST_TABLE_RATE_3);
      write_reg(REG_INITIAL_RATE, 44100);
      write_reg(REG_UNUSED, 18'h3FFFF);
      send_gap(23220);
      send_gap(21333);
      send_gap(21333);
   endtask

   task automatic test_random_traffic(input int unsigned words);
      int unsigned        stop_at;
      int unsigned        reconfig_at;
      int unsigned        kind;
      int unsigned        burst;
      int unsigned        n;
      longint             target;
      longint             spread;
      longint             lo;
      longint             hi;
      logic [STAMP_W-1:0] gap;
      stop_at     = words_sent + words;
      reconfig_at = words_sent + 60 + $urandom_range(80);
      while (words_sent < stop_at) begin
         if (words_sent >= reconfig_at) begin
            wait_quiet();
            randomize_config();
            reconfig_at = words_sent + 60 + $urandom_range(80);
         end
         spread = longint'(cfg_tol) + 50;
         lo     = table_entry(0) - longint'(cfg_tol);
         hi     = table_entry(TABLE_ENTRIES - 1) + longint'(cfg_tol);
         kind   = $urandom_range(99);
         burst  = $urandom_range(1, 4);
         if (kind < 55) begin
            target = table_entry($urandom_range(TABLE_ENTRIES - 1))
                     + longint'($urandom_range(0, 2 * spread)) - spread;
         end else if (kind < 65) begin
            target = longint'(st_rate) + longint'($urandom_range(0, 2 * spread)) - spread;
         end else if (kind < 78) begin
            if ($urandom_range(1) && lo > 0) begin
               target = longint'($urandom_range(0, lo - 1));
            end else begin
               target = hi + 1 + longint'($urandom_range(0, 300000));
            end
         end else begin
            target = -1;
            burst  = 1;
         end
         for (n = 0; n < burst; n++) begin
            if (target >= 0) begin
               gap = gap_for_rate(target);
               if (gap > 2 && $urandom_range(1)) begin
                  gap = gap + $urandom_range(2) - 1;
               end
               send_gap(gap);
            end else begin
               case ($urandom_range(2))
                  0: send_gap($urandom);
                  1: send_gap($urandom_range(3));
                  default: send_stamp($urandom);
               endcase
            end
         end
      end
      wait_quiet();
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_stamp_us  = '0;
      rsp_stall     = 1'b0;
      csr_write_en  = 1'b0;
      csr_index     = '0;
      csr_data      = '0;
      cfg_frames    = RST_PERIOD_FRAMES;
      cfg_initial   = RST_INITIAL_RATE;
      cfg_table[0]  = RST_TABLE_RATE_0;
      cfg_table[1]  = RST_TABLE_RATE_1;
      cfg_table[2]  = RST_TABLE_RATE_2;
      cfg_table[3]  = RST_TABLE_RATE_3;
      cfg_tol       = RST_TOLERANCE_HZ;
      st_last_stamp = '0;
      st_seen       = 1'b0;
      st_rate       = RST_INITIAL_RATE;
      st_misses     = '0;
      stamp_cursor  = '0;
      words_sent    = 0;
      error_count   = 0;
      send_idle_pct = 36;
      stall_pct     = 70;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_first_stamp_and_hold();
      test_saturation();
      test_confirmed_change();
      test_retry_out_of_span();
      test_snap_keeps_rate();
      test_tie_and_order();
      test_register_writes();
      test_random_traffic(RANDOM_WORDS);

      send_idle_pct = 70;
      stall_pct     = 36;
      test_random_traffic(RANDOM_WORDS);

      send_idle_pct = 0;
      stall_pct     = 0;
      test_random_traffic(RANDOM_WORDS);

      if (error_count == 0) begin
         $display("PASS audio_sample_rate_detector");
      end else begin
         $display("FAIL audio_sample_rate_detector");
      end
      $finish;
   end

endmodule
